FILE: hdl/i2r_pkg.sv
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types and constants for the integer to radix-digit converter.
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int VALUE_W        = 64;
  localparam int DIGIT_W        = 14;
  localparam int POS_W          = 3;
  localparam int COUNT_W        = 7;
  localparam int CHUNK_W        = 16;
  localparam int RADIX_DEF      = 10000;
  localparam int MAX_DIGITS_DEF = 5;

  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] value_bits;
    logic               signed_mode;
  } in_t;

  typedef struct packed {
    logic [1:0]         sign_code;
    logic [DIGIT_W-1:0] digit;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   digit_count;
    logic               last;
  } out_t;

  // classified item passed from the front end to the digit engine
  typedef struct packed {
    logic [1:0]         sign_code;
    logic [VALUE_W-1:0] magnitude;
  } job_t;

endpackage

FILE: hdl/i2r_front.sv
// ----------------------------------------------------------------------------
// i2r_front
// Splits an incoming value into sign code and unsigned magnitude.
// ----------------------------------------------------------------------------
module i2r_front
  import i2r_pkg::*;
(
  input  in_t  request,
  output job_t job
);

  logic               negative;
  logic [VALUE_W-1:0] mag;

  assign negative = request.signed_mode & request.value_bits[VALUE_W-1];
  // most negative input wraps to unsigned 2^63, which is the right magnitude
  assign mag      = negative ? ({VALUE_W{1'b0}} - request.value_bits) : request.value_bits;

  assign job.magnitude = mag;
  assign job.sign_code = (mag == '0) ? SIGN_ZERO : (negative ? SIGN_NEG : SIGN_POS);

endmodule

FILE: hdl/i2r_queue.sv
// ----------------------------------------------------------------------------
// i2r_queue
// Two-entry queue between the front end and the digit engine.
// ----------------------------------------------------------------------------
module i2r_queue
  import i2r_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic pop_valid,
  output job_t pop_job
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign full      = (fill == 2'd2);
  assign pop_valid = (fill != 2'd0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push & ~full;
  assign do_pop    = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hdl/i2r_back.sv
// ----------------------------------------------------------------------------
// i2r_back
// Digit engine: repeated division by the radix, one 16-bit chunk of the value
// at a time by reciprocal multiplication, then emission of the most
// significant digits.
// ----------------------------------------------------------------------------
module i2r_back
  import i2r_pkg::*;
#(
  parameter int RADIX      = RADIX_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_pop,
  output logic strobe,
  output out_t result
);

  localparam int DVD_W   = 2 * CHUNK_W;
  localparam int RCP_W   = DVD_W + 1;
  localparam int PROD_W  = DVD_W + RCP_W;
  localparam int RADIX_L = $clog2(RADIX);
  localparam int SHIFT   = DVD_W + RADIX_L;
  localparam int KW      = $clog2(MAX_DIGITS + 1);
  localparam int CHUNKS  = VALUE_W / CHUNK_W;
  localparam int CC_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  // ceil(2^SHIFT / RADIX): exact quotient for any 32-bit dividend
  localparam longint unsigned RECIP_V =
    ((64'd1 << SHIFT) + 64'(RADIX) - 64'd1) / 64'(RADIX);
  localparam logic [RCP_W-1:0] RECIP   = RCP_W'(RECIP_V);
  localparam logic [DVD_W-1:0] RADIX_C = DVD_W'(RADIX);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIX  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;
  logic [1:0]         sign;
  logic [VALUE_W-1:0] num;
  logic [CHUNK_W-1:0] rem;
  logic [PROD_W-1:0]  prod;
  logic [CC_W-1:0]    chunk_cnt;
  logic [COUNT_W-1:0] count;
  logic [KW-1:0]      emit_n;
  logic [KW-1:0]      k;
  logic [DIGIT_W-1:0] digit_store [MAX_DIGITS];

  logic [DVD_W-1:0]   dvd;
  logic [CHUNK_W-1:0] quo;
  logic [DVD_W-1:0]   quo_r;
  logic [CHUNK_W-1:0] rem_next;
  logic [VALUE_W-1:0] num_next;
  logic               last_chunk;
  logic [COUNT_W-1:0] count_inc;
  logic [KW-1:0]      k_inc;

  // partial dividend: running remainder over the next chunk, MS chunk first
  assign dvd        = {rem, num[VALUE_W-1 -: CHUNK_W]};
  assign quo        = prod[SHIFT +: CHUNK_W];
  assign quo_r      = DVD_W'(quo) * RADIX_C;
  assign rem_next   = CHUNK_W'(dvd - quo_r);
  assign num_next   = {num[VALUE_W-CHUNK_W-1:0], quo};
  assign last_chunk = (chunk_cnt == CC_W'(CHUNKS - 1));

  assign count_inc = count + COUNT_W'(1);
  assign k_inc     = k + KW'(1);
  assign job_pop   = (state == ST_IDLE) & job_valid;

  // digit store: shift in during division, shift out during emission
  always_ff @(posedge clk) begin
    if (state == ST_FIX && last_chunk) begin
      digit_store[0] <= DIGIT_W'(rem_next);
      for (int i = 1; i < MAX_DIGITS; i++) begin
        digit_store[i] <= digit_store[i-1];
      end
    end else if (state == ST_EMIT) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        digit_store[i] <= digit_store[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      chunk_cnt <= '0;
      count     <= '0;
      k         <= '0;
      emit_n    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          strobe <= job_valid && (job.sign_code == SIGN_ZERO);
          if (job_valid) begin
            sign      <= job.sign_code;
            num       <= job.magnitude;
            rem       <= '0;
            chunk_cnt <= '0;
            count     <= '0;
            if (job.sign_code == SIGN_ZERO) begin
              result.sign_code   <= SIGN_ZERO;
              result.digit       <= '0;
              result.position    <= '0;
              result.digit_count <= '0;
              result.last        <= 1'b1;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          strobe <= 1'b0;
          prod   <= PROD_W'(dvd) * PROD_W'(RECIP);
          state  <= ST_FIX;
        end
        ST_FIX: begin
          strobe <= 1'b0;
          num    <= num_next;
          if (last_chunk) begin
            // digit complete: restart the remainder for the next one
            rem       <= '0;
            chunk_cnt <= '0;
            count     <= count_inc;
            if (num_next == '0) begin
              state  <= ST_EMIT;
              k      <= '0;
              emit_n <= (count_inc >= COUNT_W'(MAX_DIGITS)) ? KW'(MAX_DIGITS)
                                                            : KW'(count_inc);
            end else begin
              state <= ST_MUL;
            end
          end else begin
            rem       <= rem_next;
            chunk_cnt <= chunk_cnt + CC_W'(1);
            state     <= ST_MUL;
          end
        end
        ST_EMIT: begin
          strobe             <= 1'b1;
          result.sign_code   <= sign;
          result.digit       <= digit_store[0];
          result.position    <= POS_W'(k);
          result.digit_count <= count[POS_W-1:0];
          result.last        <= (k_inc == emit_n);
          k                  <= k_inc;
          if (k_inc == emit_n) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          strobe <= 1'b0;
          state  <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_strobe_in_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL || state == ST_FIX) |-> !strobe)
    else $error("result strobe while dividing");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIX) |-> (DVD_W'(rem) < RADIX_C))
    else $error("running remainder not below radix");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |-> (state == ST_IDLE))
    else $error("last result delivered but engine not idle");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (k < emit_n))
    else $error("emission index past digit count");

  a_emit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (emit_n != '0 && count != '0))
    else $error("emission with no digits");

endmodule

FILE: hdl/int_to_radix_digits.sv
// Each radix digit takes four 16-bit chunks, each a multiply step then a
// correct step; then up to MAX_DIGITS digits are emitted, most significant
// first. A zero value is answered straight from idle. The engine takes a
// new item only when idle, after its last result; a two-entry queue buffers
// ahead.
// Reset (rst, synchronous): queue empties, engine idles; results never stall.
// ----------------------------------------------------------------------------
// int_to_radix_digits
// Converts a signed or unsigned 64-bit value to base-RADIX digits, most
// significant first, with sign, position, digit count and last marker.
// ----------------------------------------------------------------------------
module int_to_radix_digits
  import i2r_pkg::*;
#(
  parameter int RADIX      = RADIX_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  request,
  output logic strobe,
  output out_t result
);

  job_t front_job;
  job_t queue_job;
  logic queue_full;
  logic queue_valid;
  logic queue_pop;

  assign busy = queue_full;

  i2r_front u_front (
    .request (request),
    .job     (front_job)
  );

  i2r_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start),
    .push_job  (front_job),
    .pop       (queue_pop),
    .full      (queue_full),
    .pop_valid (queue_valid),
    .pop_job   (queue_job)
  );

  i2r_back #(
    .RADIX      (RADIX),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job       (queue_job),
    .job_pop   (queue_pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule
